// ===== design/sfd_pkg.sv =====
// Shared types, constants and arithmetic helpers for the stereo feedback delay.
// No dependencies; used by stereo_feedback_delay_unit and its testbench.
`timescale 1ns / 1ps

package sfd_pkg;

  // Delay store depth is a power of two; the write pointer wraps naturally.
  localparam int unsigned DELAY_AW    = 16;
  localparam int unsigned DELAY_DEPTH = 1 << DELAY_AW;

  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned GAIN_W     = 17;
  localparam int unsigned DELAY_W    = 16;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned PROD_W     = 42;  // exact gain products and mix sum
  localparam int unsigned RND_W      = 26;  // product after the Q16 rounding shift
  localparam int unsigned SUM_W      = 27;  // sample plus rounded term

  localparam logic [GAIN_W-1:0]  GAIN_ONE      = GAIN_W'(65536);
  localparam logic [DELAY_W-1:0] DELAY_RST     = DELAY_W'(24000);
  localparam logic [GAIN_W-1:0]  FEEDBACK_RST  = GAIN_W'(32768);
  localparam logic [GAIN_W-1:0]  WET_MIX_RST   = GAIN_W'(32768);
  localparam logic               BYPASS_RST    = 1'b1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_DELAY    = 2'd0,
    CFG_FEEDBACK = 2'd1,
    CFG_WET_MIX  = 2'd2,
    CFG_BYPASS   = 2'd3
  } cfg_reg_e;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t left_in;
    sample_t right_in;
  } in_beat_t;

  typedef struct packed {
    sample_t left_out;
    sample_t right_out;
  } out_beat_t;

  // One delay store word holds both channels at the same position.
  typedef struct packed {
    sample_t left;
    sample_t right;
  } stereo_t;

  function automatic logic [GAIN_W-1:0] clamp_gain(logic [GAIN_W-1:0] g);
    return (g > GAIN_ONE) ? GAIN_ONE : g;
  endfunction

  // Round to nearest, ties up, then drop 16 fraction bits.
  function automatic logic signed [RND_W-1:0] round_q16(logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + PROD_W'(32768);
    return t[PROD_W-1:16];
  endfunction

  function automatic sample_t sat24(logic signed [SUM_W-1:0] v);
    logic [SUM_W-SAMPLE_W:0] top;
    top = v[SUM_W-1:SAMPLE_W-1];
    if ((top == '0) || (top == '1)) begin
      return v[SAMPLE_W-1:0];
    end
    return v[SUM_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
  endfunction

  // Value written back: dry + wet * feedback, saturated.
  function automatic sample_t fb_value(sample_t dry, sample_t wet, logic [GAIN_W-1:0] fb);
    logic signed [PROD_W-1:0] prod;
    prod = PROD_W'(wet) * PROD_W'($signed({1'b0, fb}));
    return sat24(SUM_W'(dry) + SUM_W'(round_q16(prod)));
  endfunction

  // Unrounded mix: dry * (1 - mix) + wet * mix.
  function automatic logic signed [PROD_W-1:0] mix_sum(sample_t dry, sample_t wet,
                                                       logic [GAIN_W-1:0] mix);
    logic [GAIN_W-1:0] dry_g;
    dry_g = GAIN_ONE - mix;
    return PROD_W'(dry) * PROD_W'($signed({1'b0, dry_g}))
         + PROD_W'(wet) * PROD_W'($signed({1'b0, mix}));
  endfunction

endpackage

// ===== design/sfd_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered,
// read-first output. No dependencies.
`timescale 1ns / 1ps

module sfd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/stereo_feedback_delay_unit.sv =====
// Stereo feedback delay (echo) with dry/wet mix, top level.
// Pipeline: stage 1, stage 2, output register. Throughput: 1 beat per cycle, set
// by one read and one write per cycle on the shared delay RAM, while not stalled.
// Reset: config registers take their defaults and the write pointer returns to zero.
// The RAM is not swept; a fill mark (pointer plus wrapped flag) makes entries not
// yet written since reset read as zero, so beats are taken right after reset.
`timescale 1ns / 1ps

module stereo_feedback_delay_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sfd_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [sfd_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  sfd_pkg::in_beat_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output sfd_pkg::out_beat_t                  out_data_o
);

  localparam int unsigned AW = sfd_pkg::DELAY_AW;

  // Configuration
  logic [sfd_pkg::DELAY_W-1:0] delay_q;
  logic [sfd_pkg::GAIN_W-1:0]  fb_q, mix_q;
  logic                        byp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= sfd_pkg::DELAY_RST;
      fb_q    <= sfd_pkg::FEEDBACK_RST;
      mix_q   <= sfd_pkg::WET_MIX_RST;
      byp_q   <= sfd_pkg::BYPASS_RST;
    end else if (cfg_we_i) begin
      unique case (sfd_pkg::cfg_reg_e'(cfg_addr_i))
        sfd_pkg::CFG_DELAY:    delay_q <= cfg_data_i[sfd_pkg::DELAY_W-1:0];
        sfd_pkg::CFG_FEEDBACK: fb_q    <= sfd_pkg::clamp_gain(cfg_data_i);
        sfd_pkg::CFG_WET_MIX:  mix_q   <= sfd_pkg::clamp_gain(cfg_data_i);
        sfd_pkg::CFG_BYPASS:   byp_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Pipeline control: every stage moves when the output register can take a beat
  logic adv, accept;
  logic out_valid_q;
  sfd_pkg::out_beat_t out_data_q;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;
  assign accept     = in_valid_i && adv;

  // Write pointer and fill mark
  logic [AW-1:0] wr_q, rd_addr;
  logic          wrapped_q, rd_ok;

  assign rd_addr = wr_q - AW'(delay_q);
  // Entry holds data only if written since reset; read-before-write at zero delay
  assign rd_ok   = wrapped_q || (rd_addr < wr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q      <= '0;
      wrapped_q <= 1'b0;
    end else if (accept && !byp_q) begin
      wr_q <= wr_q + AW'(1);
      if (wr_q == '1) begin
        wrapped_q <= 1'b1;
      end
    end
  end

  // Delay RAM
  logic             ram_we;
  sfd_pkg::stereo_t ram_rdata;

  // Stage 1: read data arrives
  logic             s1_valid_q, s1_byp_q, s1_rdok_q;
  logic [AW-1:0]    s1_wr_q, s1_raddr_q;
  sfd_pkg::in_beat_t s1_dry_q;

  // Stage 2: write back pending
  logic             s2_valid_q, s2_byp_q;
  logic [AW-1:0]    s2_wr_q;
  sfd_pkg::stereo_t s2_wval_q;
  sfd_pkg::in_beat_t s2_dry_q;
  logic signed [sfd_pkg::PROD_W-1:0] s2_acc_l_q, s2_acc_r_q;

  // Most recent completed write, covers the read-first gap
  logic             lw_valid_q;
  logic [AW-1:0]    lw_addr_q;
  sfd_pkg::stereo_t lw_data_q;

  sfd_ram #(
    .WIDTH($bits(sfd_pkg::stereo_t)),
    .DEPTH(sfd_pkg::DELAY_DEPTH)
  ) u_delay_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(s2_wr_q),
    .wdata_i(s2_wval_q),
    .re_i   (accept && !byp_q),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_byp_q   <= byp_q;
      s1_rdok_q  <= rd_ok;
      s1_wr_q    <= wr_q;
      s1_raddr_q <= rd_addr;
      s1_dry_q   <= in_data_i;
    end
  end

  // Wet select: pending write, then last write, then RAM, else never written
  sfd_pkg::stereo_t wet, wval;

  always_comb begin
    priority if (s2_valid_q && !s2_byp_q && (s2_wr_q == s1_raddr_q)) begin
      wet = s2_wval_q;
    end else if (lw_valid_q && (lw_addr_q == s1_raddr_q)) begin
      wet = lw_data_q;
    end else if (s1_rdok_q) begin
      wet = ram_rdata;
    end else begin
      wet = '0;
    end
    wval.left  = sfd_pkg::fb_value(s1_dry_q.left_in, wet.left, fb_q);
    wval.right = sfd_pkg::fb_value(s1_dry_q.right_in, wet.right, fb_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q) begin
      s2_byp_q   <= s1_byp_q;
      s2_wr_q    <= s1_wr_q;
      s2_wval_q  <= wval;
      s2_dry_q   <= s1_dry_q;
      s2_acc_l_q <= sfd_pkg::mix_sum(s1_dry_q.left_in, wet.left, mix_q);
      s2_acc_r_q <= sfd_pkg::mix_sum(s1_dry_q.right_in, wet.right, mix_q);
    end
  end

  assign ram_we = adv && s2_valid_q && !s2_byp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_valid_q <= 1'b0;
    end else if (ram_we) begin
      lw_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      lw_addr_q <= s2_wr_q;
      lw_data_q <= s2_wval_q;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_valid_q) begin
      if (s2_byp_q) begin
        out_data_q.left_out  <= s2_dry_q.left_in;
        out_data_q.right_out <= s2_dry_q.right_in;
      end else begin
        out_data_q.left_out  <=
          sfd_pkg::sat24(sfd_pkg::SUM_W'(sfd_pkg::round_q16(s2_acc_l_q)));
        out_data_q.right_out <=
          sfd_pkg::sat24(sfd_pkg::SUM_W'(sfd_pkg::round_q16(s2_acc_r_q)));
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== tb/tb_stereo_feedback_delay_unit.sv =====
// Testbench for stereo_feedback_delay_unit: directed and random stereo beats checked
// against an in-bench echo line model with its own delay stores and register copies.
// Depends on sfd_pkg and the RTL of stereo_feedback_delay_unit and sfd_ram only.
`timescale 1ns / 1ps

module tb_stereo_feedback_delay_unit;
  import sfd_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_TAIL  = 8;
  localparam int S_MAX       = 8388607;
  localparam int S_MIN       = -8388608;
  localparam int RANDOM_BEATS = 380;

  typedef bit signed [SAMPLE_W-1:0] line_word_t;

  logic                  clk_i    = 1'b0;
  logic                  rst_ni   = 1'b0;
  logic                  cfg_we   = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_beat_t              in_data  = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_beat_t             out_data;

  // Echo line model: two stores, write pointer and register copies.
  line_word_t          echo_line [2][DELAY_DEPTH];
  logic [DELAY_AW-1:0] echo_wr_pos = '0;
  logic [DELAY_W-1:0]  delay_len   = DELAY_RST;
  logic [GAIN_W-1:0]   fb_gain     = FEEDBACK_RST;
  logic [GAIN_W-1:0]   mix_gain    = WET_MIX_RST;
  logic                bypass_on   = BYPASS_RST;
  out_beat_t           echo_expected [$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int in_gap_max     = 0;
  int out_gap_max    = 0;
  int out_hold_len   = 0;

  stereo_feedback_delay_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_addr_i  (cfg_addr),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial forever #4 clk_i = ~clk_i;

  function automatic longint round_gain(longint p);
    return (p + 32768) >>> 16;
  endfunction

  function automatic sample_t clip_sample(longint v);
    if (v > S_MAX) return sample_t'(S_MAX);
    if (v < S_MIN) return sample_t'(S_MIN);
    return sample_t'(v);
  endfunction

  function automatic longint limit_gain(logic [GAIN_W-1:0] g);
    return (g > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(g);
  endfunction

  // One stereo beat through the echo line; updates the stores and the pointer.
  function automatic out_beat_t echo_step(in_beat_t b);
    out_beat_t           r;
    sample_t             res [2];
    logic [DELAY_AW-1:0] rd_pos;
    longint              dry;
    longint              wet;
    longint              fb;
    longint              mix;
    if (bypass_on) begin
      r.left_out  = b.left_in;
      r.right_out = b.right_in;
      return r;
    end
    // zero delay lands on the write slot itself: read first, so it sees a full lap back
    rd_pos = echo_wr_pos - DELAY_AW'(delay_len);
    fb     = limit_gain(fb_gain);
    mix    = limit_gain(mix_gain);
    for (int c = 0; c < 2; c++) begin
      dry = (c == 0) ? $signed(b.left_in) : $signed(b.right_in);
      wet = echo_line[c][rd_pos];
      echo_line[c][echo_wr_pos] = clip_sample(dry + round_gain(wet * fb));
      res[c] = clip_sample(round_gain(dry * (65536 - mix) + wet * mix));
    end
    echo_wr_pos++;
    r.left_out  = res[0];
    r.right_out = res[1];
    return r;
  endfunction

  // Prediction on each input beat, compare on each output beat.
  always @(posedge clk_i) begin : scoreboard
    out_beat_t want;
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        echo_expected.push_back(echo_step(in_data));
      end
      if (out_valid && out_ready) begin
        if (echo_expected.size() == 0) begin
          $error("output beat with nothing expected: left_out %0d right_out %0d",
                 out_data.left_out, out_data.right_out);
          mismatch_count++;
        end else begin
          want = echo_expected.pop_front();
          if (out_data.left_out !== want.left_out) begin
            $error("left_out: expected %0d, got %0d", want.left_out, out_data.left_out);
            mismatch_count++;
          end
          if (out_data.right_out !== want.right_out) begin
            $error("right_out: expected %0d, got %0d", want.right_out, out_data.right_out);
            mismatch_count++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d beats outstanding", CYCLE_LIMIT,
             echo_expected.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Output side: per-beat random stall, or one long hold when requested.
  initial begin : receiver
    int stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (out_hold_len > 0) begin
        stall        = out_hold_len;
        out_hold_len = 0;
      end else begin
        stall = $urandom_range(out_gap_max);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  task automatic set_reg(input cfg_reg_e idx, input int unsigned val);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= CFG_DATA_W'(val);
    case (idx)
      CFG_DELAY:    delay_len = DELAY_W'(val);
      CFG_FEEDBACK: fb_gain   = GAIN_W'(val);
      CFG_WET_MIX:  mix_gain  = GAIN_W'(val);
      CFG_BYPASS:   bypass_on = val[0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_echo(input int unsigned d, input int unsigned fb,
                          input int unsigned mix, input int unsigned byp);
    set_reg(CFG_DELAY, d);
    set_reg(CFG_FEEDBACK, fb);
    set_reg(CFG_WET_MIX, mix);
    set_reg(CFG_BYPASS, byp);
  endtask

  // Valid is only dropped when a gap is drawn, so back-to-back beats keep it high.
  task automatic send_pair(input int l, input int r);
    int gap;
    gap = $urandom_range(in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{left_in: sample_t'(l), right_in: sample_t'(r)};
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (echo_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_TAIL) @(posedge clk_i);
  endtask

  function automatic int rand_sample();
    case ($urandom_range(7))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return int'($urandom_range(64)) - 32;
      default: return int'($urandom);
    endcase
  endfunction

  function automatic int unsigned rand_gain();
    case ($urandom_range(5))
      0:       return 0;
      1:       return GAIN_ONE;
      2:       return $urandom_range(131071, 65537);
      default: return $urandom_range(65536);
    endcase
  endfunction

  function automatic int unsigned rand_delay();
    case ($urandom_range(7))
      0:       return 0;
      1:       return 65535;
      2:       return $urandom_range(65535, 600);
      default: return $urandom_range(40, 1);
    endcase
  endfunction

  function automatic int pick_gap();
    case ($urandom_range(2))
      0:       return 0;
      1:       return 3;
      default: return 17;
    endcase
  endfunction

  task automatic test_defaults();
    in_gap_max  = 0;
    out_gap_max = 0;
    // comes out of reset in bypass
    send_pair(S_MAX, S_MIN);
    send_pair(0, -1);
    drain_results();
    // default gains, default delay still pointing at untouched entries
    set_reg(CFG_BYPASS, 0);
    send_pair(S_MAX, S_MIN);
    send_pair(-1, 1);
    drain_results();
  endtask

  task automatic test_directed();
    in_gap_max  = 3;
    out_gap_max = 3;
    // full wet, unity feedback: stored values saturate
    set_echo(1, GAIN_ONE, GAIN_ONE, 0);
    send_pair(S_MAX, S_MAX);
    send_pair(S_MAX, S_MIN);
    send_pair(S_MAX, S_MAX);
    send_pair(S_MIN, S_MIN);
    send_pair(S_MIN, S_MAX);
    send_pair(0, 0);
    drain_results();
    // gains above one act as one
    set_echo(1, 131071, 131071, 0);
    send_pair(S_MIN, 1);
    send_pair(1, -1);
    send_pair(-1, S_MIN);
    drain_results();
    // dry only, no feedback
    set_echo(1, 0, 0, 0);
    send_pair(12345, -12345);
    send_pair(S_MIN, S_MAX);
    drain_results();
    set_echo(0, 49152, 16384, 0);
    send_pair(S_MAX, S_MIN);
    send_pair(7, -7);
    drain_results();
    // bypass must leave the write pointer where it was
    set_reg(CFG_BYPASS, 1);
    send_pair(1, 2);
    drain_results();
    set_echo(2, 32768, 32768, 0);
    send_pair(3, 4);
    send_pair(5, 6);
    send_pair(7, 8);
    drain_results();
  endtask

  // Zero and longest delay both land on entries not yet written this lap.
  task automatic test_pointer_wrap();
    in_gap_max  = 0;
    out_gap_max = 0;
    set_echo(0, 49152, $urandom_range(65536), 0);
    repeat (64) send_pair(rand_sample(), rand_sample());
    drain_results();
    in_gap_max  = 17;
    out_gap_max = 17;
    set_echo(65535, GAIN_ONE, 40000, 0);
    repeat (64) send_pair(rand_sample(), rand_sample());
    drain_results();
  endtask

  task automatic test_random();
    int sent;
    int n;
    sent = 0;
    while (sent < RANDOM_BEATS) begin
      set_echo(rand_delay(), rand_gain(), rand_gain(), ($urandom_range(5) == 0));
      in_gap_max  = pick_gap();
      out_gap_max = pick_gap();
      n = $urandom_range(80, 20);
      repeat (n) send_pair(rand_sample(), rand_sample());
      sent += n;
      drain_results();
    end
  endtask

  task automatic test_backpressure();
    set_echo(5, 40000, 30000, 0);
    in_gap_max   = 0;
    out_gap_max  = 0;
    out_hold_len = 300;
    repeat (80) send_pair(rand_sample(), rand_sample());
    // sender waits for every result before going on
    drain_results();
    out_gap_max = 17;
    repeat (30) send_pair(rand_sample(), rand_sample());
    drain_results();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    test_directed();
    test_pointer_wrap();
    test_random();
    test_backpressure();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
